// ===== design/rgba_pkg.sv =====
// ----------------------------------------------------------------------------
// rgba_pkg
// shared types and constants for the rgba8 pixel store with source-over blend
// ----------------------------------------------------------------------------
package rgba_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int CfgW         = 9;
  localparam int PosW         = 16;
  localparam int ChW          = 8;
  localparam int PixW         = 32;
  localparam int QDepth       = 2;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_STORE = 2'd1,
    FN_BLEND = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    func_t             func;
    logic              hit;
    logic [PosW-1:0]   xi;
    logic [PosW-1:0]   yi;
    logic [PixW-1:0]   src;
  } cmd_t;

endpackage

// ===== design/rgba8_pixel_store_blend_over.sv =====
// ----------------------------------------------------------------------------
// rgba8_pixel_store_blend_over
// rgba8 frame store: load, store, source-over blend and clear
// ----------------------------------------------------------------------------
// load: ADDR, READ, LOAD (no READ when out of range); store: ADDR, WRITE;
// blend: ADDR, READ, MUL1, MUL2, DIV per color channel (one shared 36-step
// divider), WRITE; clear: ADDR, FILL of w*h words; the back end runs one
// command at a time; after reset all MAX_WIDTH*MAX_HEIGHT words are zeroed
// before the first command runs; commands queue meanwhile (busy when 2 wait)
// results are strobed for one cycle on out_valid and cannot be stalled
module rgba8_pixel_store_blend_over #(
  parameter int MAX_WIDTH  = rgba_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rgba_pkg::MaxHeightDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic [7:0]          in_src_red,
  input  logic [7:0]          in_src_green,
  input  logic [7:0]          in_src_blue,
  input  logic [7:0]          in_src_alpha,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata,
  output logic                out_valid,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha
);

  logic [8:0]     width_r, height_r, eff_w, eff_h;
  logic           q_valid, q_pop;
  rgba_pkg::cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == rgba_pkg::CFG_WIDTH) begin
        width_r <= cfg_wdata;
      end else begin
        height_r <= cfg_wdata;
      end
    end
  end

  assign eff_w = (32'(width_r) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
  assign eff_h = (32'(height_r) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r;

  rgba_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .start, .busy, .in_func, .in_pos_x, .in_pos_y,
    .in_src_red, .in_src_green, .in_src_blue, .in_src_alpha,
    .eff_w, .eff_h, .q_valid, .q_cmd, .q_pop
  );

  rgba_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst_n, .eff_w, .eff_h, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_red, .out_green, .out_blue, .out_alpha
  );

endmodule

// ===== design/rgba_front.sv =====
// ----------------------------------------------------------------------------
// rgba_front
// accepts commands, checks the coordinate range and queues them
// ----------------------------------------------------------------------------
module rgba_front #(
  parameter int MAX_WIDTH  = rgba_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rgba_pkg::MaxHeightDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic signed [15:0]         in_pos_x,
  input  logic signed [15:0]         in_pos_y,
  input  logic [7:0]                 in_src_red,
  input  logic [7:0]                 in_src_green,
  input  logic [7:0]                 in_src_blue,
  input  logic [7:0]                 in_src_alpha,
  input  logic [rgba_pkg::CfgW-1:0]  eff_w,
  input  logic [rgba_pkg::CfgW-1:0]  eff_h,
  output logic                       q_valid,
  output rgba_pkg::cmd_t             q_cmd,
  input  logic                       q_pop
);

  rgba_pkg::cmd_t q_r [rgba_pkg::QDepth];
  logic           rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           hit;
  rgba_pkg::cmd_t cmd;

  assign busy = (cnt_r == 2'(rgba_pkg::QDepth));
  assign push = start && !busy;

  always_comb begin
    hit = !in_pos_x[15] && !in_pos_y[15] &&
          (17'(unsigned'(in_pos_x)) < 17'(eff_w)) &&
          (17'(unsigned'(in_pos_y)) < 17'(eff_h));
    cmd.func   = rgba_pkg::func_t'(in_func);
    cmd.hit    = hit;
    cmd.xi     = in_pos_x;
    cmd.yi     = in_pos_y;
    cmd.src    = {in_src_alpha, in_src_blue, in_src_green, in_src_red};
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_r];

  always_comb begin
    rd_nxt  = q_pop ? !rd_r : rd_r;
    wr_nxt  = push ? !wr_r : wr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(rgba_pkg::QDepth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(rgba_pkg::QDepth)) |-> busy) else $error("full but not busy");
`endif

endmodule

// ===== design/rgba_div.sv =====
// ----------------------------------------------------------------------------
// rgba_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rgba_div #(
  parameter int NW = 36,
  parameter int DW = 26
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial   = {rem_r[DW-1:0], q_r[NW-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(NW);
      rem_nxt = '0;
      q_nxt   = num;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      d_r <= den;
    end
  end

  assign done = run_r && (cnt_r == CW'(1));
  assign quo  = q_nxt;

endmodule

// ===== design/rgba_back.sv =====
// ----------------------------------------------------------------------------
// rgba_back
// executes queued commands against the frame memory; blends via one divider
// ----------------------------------------------------------------------------
module rgba_back #(
  parameter int MAX_WIDTH  = rgba_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rgba_pkg::MaxHeightDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rgba_pkg::CfgW-1:0]  eff_w,
  input  logic [rgba_pkg::CfgW-1:0]  eff_h,
  input  logic                       q_valid,
  input  rgba_pkg::cmd_t             q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_alpha
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IW    = $clog2(Depth + 1);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ADDR  = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_MUL1  = 10'b0000010000,
    S_MUL2  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_WRITE = 10'b0010000000,
    S_FILL  = 10'b0100000000,
    S_LOAD  = 10'b1000000000
  } state_t;

  state_t            st_r, st_nxt;
  logic [rgba_pkg::PixW-1:0] mem [Depth];
  logic [rgba_pkg::PixW-1:0] rdata_r;
  rgba_pkg::cmd_t    cmd_r;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [IW-1:0]     pos_r, pos_nxt, total_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [rgba_pkg::PixW-1:0] wdata;
  logic [1:0]        ch_r, ch_nxt;
  logic [16:0]       den_r;
  logic [15:0]       sp_r, dp_r;
  logic [23:0]       ts_r, td_r;
  logic [7:0]        res_r [3];
  logic              div_go_r, div_done;
  logic [35:0]       div_num, div_quo;
  logic [7:0]        sa, da, ch_s, ch_d;
  logic [17:0]       prod_w;
  logic [17:0]       total_nxt;
  logic [17:0]       a_sum;
  logic [7:0]        a_quo;
  logic              out_v_r;
  logic [31:0]       out_d_r;

  assign sa   = cmd_r.src[31:24];
  assign da   = rdata_r[31:24];
  assign ch_s = cmd_r.src[8*ch_r +: 8];
  assign ch_d = rdata_r[8*ch_r +: 8];
  assign prod_w = 18'(cmd_r.yi) * 18'(eff_w);
  assign total_nxt = 18'(eff_w) * 18'(eff_h);

  // alpha = (D + 127) / 255 as (x + x/256 + 1) / 256
  assign a_sum = 18'(den_r) + 18'd127;
  assign a_quo = 8'((a_sum + (a_sum >> 8) + 18'd1) >> 8);

  // 2N + D over 2D gives N/D rounded half up
  assign div_num = {ts_r + td_r, 1'b0} + 36'(den_r);

  rgba_div #(.NW(36), .DW(26)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (div_num),
    .den   ({8'd0, den_r, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    st_nxt   = st_r;
    addr_nxt = addr_r;
    pos_nxt  = pos_r;
    ch_nxt   = ch_r;
    q_pop    = 1'b0;
    we       = 1'b0;
    waddr    = addr_r;
    wdata    = '0;
    unique case (st_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = pos_r[AW-1:0];
        pos_nxt = pos_r + 1'b1;
        if (pos_r == IW'(Depth - 1)) begin
          st_nxt  = S_IDLE;
          pos_nxt = '0;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_nxt = AW'(prod_w + 18'(cmd_r.xi));
        pos_nxt  = '0;
        unique case (cmd_r.func)
          rgba_pkg::FN_CLEAR: st_nxt = (total_r == '0) ? S_IDLE : S_FILL;
          rgba_pkg::FN_STORE: st_nxt = cmd_r.hit ? S_WRITE : S_IDLE;
          rgba_pkg::FN_BLEND: st_nxt = cmd_r.hit ? S_READ : S_IDLE;
          default:            st_nxt = cmd_r.hit ? S_READ : S_LOAD;
        endcase
      end
      S_READ: begin
        ch_nxt = 2'd0;
        st_nxt = (cmd_r.func == rgba_pkg::FN_LOAD) ? S_LOAD : S_MUL1;
      end
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (ch_r == 2'd2) begin
            st_nxt = S_WRITE;
          end else begin
            ch_nxt = ch_r + 1'b1;
            st_nxt = S_MUL1;
          end
        end
      end
      S_WRITE: begin
        we = 1'b1;
        if (cmd_r.func == rgba_pkg::FN_STORE) begin
          wdata = cmd_r.src;
        end else if (den_r == '0) begin
          wdata = '0;
        end else begin
          wdata = {a_quo, res_r[2], res_r[1], res_r[0]};
        end
        st_nxt = S_IDLE;
      end
      S_FILL: begin
        we      = 1'b1;
        waddr   = pos_r[AW-1:0];
        wdata   = cmd_r.src;
        pos_nxt = pos_r + 1'b1;
        if (pos_r + 1'b1 == total_r) begin
          st_nxt  = S_IDLE;
          pos_nxt = '0;
        end
      end
      S_LOAD: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_INIT;
      pos_r    <= '0;
      out_v_r  <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pos_r    <= pos_nxt;
      out_v_r  <= (st_r == S_LOAD);
      // divider starts once the channel products are registered
      div_go_r <= (st_r == S_MUL2);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[addr_r];
    addr_r  <= addr_nxt;
    ch_r    <= ch_nxt;
    total_r <= IW'(total_nxt);
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (st_r == S_MUL1) begin
      den_r <= 17'(16'(sa) * 16'd255) + 17'(16'(da) * (16'd255 - 16'(sa)));
      sp_r <= 16'(ch_s) * 16'(sa);
      dp_r <= 16'(ch_d) * 16'(da);
    end
    if (st_r == S_MUL2) begin
      ts_r <= 24'(sp_r) * 24'd255;
      td_r <= 24'(dp_r) * 24'(8'd255 - sa);
    end
    if (div_done) begin
      res_r[ch_r] <= (div_quo > 36'd255) ? 8'd255 : div_quo[7:0];
    end
    if (st_r == S_LOAD) begin
      out_d_r <= cmd_r.hit ? rdata_r : '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_red   = out_d_r[7:0];
  assign out_green = out_d_r[15:8];
  assign out_blue  = out_d_r[23:16];
  assign out_alpha = out_d_r[31:24];

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == S_IDLE)) else $error("pop outside idle");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == S_LOAD)) else $error("stray result");
`endif

endmodule
